// ----- hw/rtl/ctsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsp_pkg
// Types, codes and limits shared by the crontab time-field parser modules.
// ----------------------------------------------------------------------------
package ctsp_pkg;

  // one input transaction: a character and a start-of-line flag
  typedef struct packed {
    logic       line_start;
    logic [7:0] ch;
  } char_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [59:0] minute_bits;
    logic [23:0] hour_bits;
    logic [31:0] mday_bits;
    logic [12:0] month_bits;
    logic [7:0]  wday_bits;
  } result_t;

  // result status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_NUM = 2'd1;
  localparam logic [1:0] STATUS_BAD = 2'd2;

  // how an item ended
  localparam logic [1:0] END_NONE  = 2'd0;
  localparam logic [1:0] END_ITEM  = 2'd1;
  localparam logic [1:0] END_FIELD = 2'd2;

  // field codes
  localparam logic [2:0] FLD_MINUTE = 3'd0;
  localparam logic [2:0] FLD_HOUR   = 3'd1;
  localparam logic [2:0] FLD_MDAY   = 3'd2;
  localparam logic [2:0] FLD_MONTH  = 3'd3;
  localparam logic [2:0] FLD_WDAY   = 3'd4;

  localparam logic [7:0] MINUTE_MAX = 8'd59;
  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MDAY_MAX   = 8'd31;
  localparam logic [7:0] MONTH_MIN  = 8'd1;
  localparam logic [7:0] MONTH_MAX  = 8'd12;
  localparam logic [7:0] WDAY_MAX   = 8'd7;

  // characters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_START,
    PH_ITEM,
    PH_LO,
    PH_HI,
    PH_STAR,
    PH_STEP
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TAKE,
    CMD_EXP_INIT,
    CMD_EXP_STEP,
    CMD_FINISH,
    CMD_LOAD_OUT
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_INIT,
    ST_EXPAND,
    ST_FINISH,
    ST_EMIT
  } ctl_state_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [1:0] take_err;
    logic [1:0] take_end;
    logic       exp_last;
    logic       line_result;
  } dp_status_t;

  function automatic logic [7:0] lim_min(input logic [2:0] fld);
    lim_min = (fld == FLD_MONTH) ? MONTH_MIN : 8'd0;
  endfunction

  function automatic logic [7:0] lim_max(input logic [2:0] fld);
    case (fld)
      FLD_MINUTE: lim_max = MINUTE_MAX;
      FLD_HOUR:   lim_max = HOUR_MAX;
      FLD_MDAY:   lim_max = MDAY_MAX;
      FLD_MONTH:  lim_max = MONTH_MAX;
      default:    lim_max = WDAY_MAX;
    endcase
  endfunction

  function automatic logic [2:0] clamp_field(input logic [2:0] fld);
    clamp_field = (fld > FLD_WDAY) ? FLD_WDAY : fld;
  endfunction

endpackage

// ----- hw/rtl/ctsp_dp.sv -----
// ----------------------------------------------------------------------------
// ctsp_dp
// Parser datapath: character decode, number accumulate, range expansion
// into the field masks, and the result register.
// ----------------------------------------------------------------------------
module ctsp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ctsp_pkg::cmd_t       cmd,
  input  ctsp_pkg::char_t      char_item,
  output ctsp_pkg::dp_status_t sts,
  output ctsp_pkg::result_t    result
);
  import ctsp_pkg::*;

  // parse state
  logic [2:0]  field_index;
  phase_t      phase;
  logic [7:0]  value_acc;
  logic        digits_seen;
  logic [7:0]  range_low;
  logic [7:0]  range_high;
  logic [7:0]  step_size;
  logic        done_flag;
  logic [1:0]  end_code;
  logic [1:0]  err_code;
  logic [59:0] minute_store;
  logic [23:0] hour_store;
  logic [31:0] mday_store;
  logic [12:0] month_store;
  logic [7:0]  wday_store;
  logic [8:0]  exp_v;
  logic [7:0]  exp_step;

  // state as seen by this character (line_start clears first)
  logic [2:0] e_field;
  phase_t     e_phase;
  logic [7:0] e_acc;
  logic       e_dseen;
  logic [7:0] e_lo;
  logic [7:0] e_hi;
  logic [7:0] e_step;
  logic       e_done;
  logic [2:0] e_fld;

  // decoded next state
  phase_t     n_phase;
  logic [7:0] n_acc;
  logic       n_dseen;
  logic [7:0] n_lo;
  logic [7:0] n_hi;
  logic [7:0] n_step;
  logic [1:0] take_err;
  logic [1:0] take_end;

  logic [7:0]  c;
  logic        is_ws;
  logic        is_digit;
  logic        is_delim;
  logic [1:0]  bad_code;
  logic [1:0]  bound_code;
  logic [11:0] acc_prod;
  logic [7:0]  acc_sat;

  // expansion
  logic [2:0]  cur_fld;
  logic [8:0]  exp_next;
  logic        set_en;
  logic [8:0]  wday_v;
  logic [59:0] minute_set;
  logic [23:0] hour_set;
  logic [31:0] mday_set;
  logic [12:0] month_set;
  logic [7:0]  wday_set;

  assign c        = char_item.ch;
  assign is_ws    = (c inside {CH_SPACE, [CH_TAB:CH_CR]});
  assign is_digit = (c inside {[CH_ZERO:CH_NINE]});
  assign is_delim = (c inside {CH_COMMA, CH_DASH, CH_SLASH}) || is_ws;

  always_comb begin
    if (char_item.line_start) begin
      e_field = FLD_MINUTE;
      e_phase = PH_START;
      e_acc   = 8'd0;
      e_dseen = 1'b0;
      e_lo    = 8'd0;
      e_hi    = 8'd0;
      e_step  = 8'd0;
      e_done  = 1'b0;
    end else begin
      e_field = field_index;
      e_phase = phase;
      e_acc   = value_acc;
      e_dseen = digits_seen;
      e_lo    = range_low;
      e_hi    = range_high;
      e_step  = step_size;
      e_done  = done_flag;
    end
  end

  assign e_fld = clamp_field(e_field);

  // decimal accumulate, saturating at 255
  assign acc_prod = 12'(e_acc) * 12'd10 + 12'(c - CH_ZERO);
  assign acc_sat  = (acc_prod > 12'd255) ? 8'hFF : acc_prod[7:0];

  assign bad_code = (is_delim && !e_dseen) ? STATUS_NUM : STATUS_BAD;

  always_comb begin
    if (!e_dseen) begin
      bound_code = STATUS_NUM;
    end else if (e_acc < lim_min(e_fld) || e_acc > lim_max(e_fld)) begin
      bound_code = STATUS_BAD;
    end else begin
      bound_code = STATUS_OK;
    end
  end

  always_comb begin
    n_phase  = e_phase;
    n_acc    = e_acc;
    n_dseen  = e_dseen;
    n_lo     = e_lo;
    n_hi     = e_hi;
    n_step   = e_step;
    take_err = STATUS_OK;
    take_end = END_NONE;
    if (!e_done) begin
      case (e_phase)
        PH_START, PH_ITEM: begin
          if (!(e_phase == PH_START && is_ws)) begin
            n_lo    = 8'd0;
            n_hi    = 8'd0;
            n_step  = 8'd0;
            n_acc   = 8'd0;
            n_dseen = 1'b0;
            if (is_digit) begin
              n_acc   = 8'(c - CH_ZERO);
              n_dseen = 1'b1;
              n_phase = PH_LO;
            end else if (c == CH_STAR) begin
              n_lo    = lim_min(e_fld);
              n_hi    = lim_max(e_fld);
              n_phase = PH_STAR;
            end else begin
              // number was just cleared, so a delimiter here is an empty number
              take_err = is_delim ? STATUS_NUM : STATUS_BAD;
            end
          end
        end
        PH_LO, PH_HI: begin
          if (is_digit) begin
            n_acc   = acc_sat;
            n_dseen = 1'b1;
          end else if ((c == CH_DASH && e_phase == PH_LO) || c == CH_SLASH ||
                       c == CH_COMMA || is_ws) begin
            if (bound_code != STATUS_OK) begin
              take_err = bound_code;
            end else begin
              if (e_phase == PH_LO) begin
                n_lo = e_acc;
              end else begin
                n_hi = e_acc;
              end
              n_acc   = 8'd0;
              n_dseen = 1'b0;
              if (c == CH_DASH) begin
                n_phase = PH_HI;
              end else if (c == CH_SLASH) begin
                n_phase = PH_STEP;
              end else begin
                take_end = (c == CH_COMMA) ? END_ITEM : END_FIELD;
              end
            end
          end else begin
            take_err = bad_code;
          end
        end
        PH_STAR: begin
          if (c == CH_SLASH) begin
            n_phase = PH_STEP;
          end else if (c == CH_COMMA) begin
            take_end = END_ITEM;
          end else if (is_ws) begin
            take_end = END_FIELD;
          end else begin
            take_err = STATUS_BAD;
          end
        end
        PH_STEP: begin
          if (is_digit) begin
            n_acc   = acc_sat;
            n_dseen = 1'b1;
          end else if ((c == CH_COMMA || is_ws) && e_dseen) begin
            n_step   = e_acc;
            n_acc    = 8'd0;
            n_dseen  = 1'b0;
            take_end = (c == CH_COMMA) ? END_ITEM : END_FIELD;
          end else begin
            take_err = bad_code;
          end
        end
        default: take_err = STATUS_BAD;
      endcase
    end
  end

  // one value of the range per step; a zero range end means a single value
  assign cur_fld  = clamp_field(field_index);
  assign exp_next = exp_v + 9'(exp_step);
  assign set_en   = (range_high == 8'd0) || (exp_v <= 9'(range_high));
  assign wday_v   = (exp_v == 9'd0) ? 9'(WDAY_MAX) : exp_v;

  always_comb begin
    minute_set = minute_store;
    hour_set   = hour_store;
    mday_set   = mday_store;
    month_set  = month_store;
    wday_set   = wday_store;
    if (set_en) begin
      case (cur_fld)
        FLD_MINUTE: begin
          if (exp_v <= 9'(MINUTE_MAX)) minute_set = minute_store | (60'd1 << exp_v[5:0]);
        end
        FLD_HOUR: begin
          if (exp_v <= 9'(HOUR_MAX)) hour_set = hour_store | (24'd1 << exp_v[4:0]);
        end
        FLD_MDAY: begin
          if (exp_v <= 9'(MDAY_MAX)) mday_set = mday_store | (32'd1 << exp_v[4:0]);
        end
        FLD_MONTH: begin
          if (exp_v >= 9'(MONTH_MIN) && exp_v <= 9'(MONTH_MAX)) begin
            month_set = month_store | (13'd1 << exp_v[3:0]);
          end
        end
        default: begin
          if (wday_v <= 9'(WDAY_MAX)) wday_set = wday_store | (8'd1 << wday_v[2:0]);
        end
      endcase
    end
  end

  assign sts.take_err    = take_err;
  assign sts.take_end    = take_end;
  assign sts.exp_last    = (range_high == 8'd0) || (exp_next > 9'(range_high));
  assign sts.line_result = (end_code == END_FIELD) && (cur_fld == FLD_WDAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index  <= FLD_MINUTE;
      phase        <= PH_START;
      value_acc    <= 8'd0;
      digits_seen  <= 1'b0;
      range_low    <= 8'd0;
      range_high   <= 8'd0;
      step_size    <= 8'd0;
      done_flag    <= 1'b0;
      end_code     <= END_NONE;
      err_code     <= STATUS_OK;
      minute_store <= '0;
      hour_store   <= '0;
      mday_store   <= '0;
      month_store  <= '0;
      wday_store   <= '0;
      exp_v        <= '0;
      exp_step     <= '0;
    end else begin
      case (cmd)
        CMD_TAKE: begin
          field_index <= e_field;
          phase       <= n_phase;
          value_acc   <= n_acc;
          digits_seen <= n_dseen;
          range_low   <= n_lo;
          range_high  <= n_hi;
          step_size   <= n_step;
          end_code    <= take_end;
          done_flag   <= e_done || (take_err != STATUS_OK);
          if (take_err != STATUS_OK) begin
            err_code <= take_err;
          end
          if (char_item.line_start) begin
            minute_store <= '0;
            hour_store   <= '0;
            mday_store   <= '0;
            month_store  <= '0;
            wday_store   <= '0;
          end
        end
        CMD_EXP_INIT: begin
          exp_v    <= 9'(range_low);
          exp_step <= (step_size == 8'd0) ? 8'd1 : step_size;
        end
        CMD_EXP_STEP: begin
          minute_store <= minute_set;
          hour_store   <= hour_set;
          mday_store   <= mday_set;
          month_store  <= month_set;
          wday_store   <= wday_set;
          exp_v        <= exp_next;
        end
        CMD_FINISH: begin
          if (end_code == END_ITEM) begin
            phase <= PH_ITEM;
          end else if (cur_fld != FLD_WDAY) begin
            field_index <= cur_fld + 3'd1;
            phase       <= PH_START;
          end else begin
            done_flag <= 1'b1;
            err_code  <= STATUS_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // result register, masks zeroed on an error
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD_OUT) begin
      result.status <= err_code;
      if (err_code != STATUS_OK) begin
        result.minute_bits <= '0;
        result.hour_bits   <= '0;
        result.mday_bits   <= '0;
        result.month_bits  <= '0;
        result.wday_bits   <= '0;
      end else begin
        result.minute_bits <= minute_store;
        result.hour_bits   <= hour_store;
        result.mday_bits   <= mday_store;
        result.month_bits  <= month_store;
        result.wday_bits   <= wday_store;
      end
    end
  end

endmodule

// ----- hw/rtl/ctsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctsp_ctrl
// Parser controller: handshakes, sequencing of decode, expansion and result.
// ----------------------------------------------------------------------------
module ctsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  ctsp_pkg::dp_status_t sts,
  output ctsp_pkg::cmd_t       cmd
);
  import ctsp_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    char_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        char_ready = 1'b1;
        if (char_valid) begin
          cmd = CMD_TAKE;
          if (sts.take_err != STATUS_OK) begin
            state_next = ST_EMIT;
          end else if (sts.take_end != END_NONE) begin
            state_next = ST_EXP_INIT;
          end
        end
      end
      ST_EXP_INIT: begin
        cmd        = CMD_EXP_INIT;
        state_next = ST_EXPAND;
      end
      ST_EXPAND: begin
        cmd = CMD_EXP_STEP;
        if (sts.exp_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd        = CMD_FINISH;
        state_next = sts.line_result ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // wait for a free result register
        if (!result_valid || result_ready) begin
          cmd        = CMD_LOAD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd == CMD_LOAD_OUT) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/cron_time_spec_parser.sv -----
// ----------------------------------------------------------------------------
// cron_time_spec_parser
// Parses the five time fields of a crontab line into minute, hour, day of
// month, month and weekday bit masks.
// ----------------------------------------------------------------------------
// usage:
//   char channel (char_valid/char_ready/char_item) takes one character per
//   transaction; line_start set on the first character of a line clears the
//   parse state and masks before that character is decoded
//   result channel (result_valid/result_ready/result) gives one transaction
//   per line: on the whitespace that ends the fifth field (status ok and the
//   masks) or on the first error (error status, masks zero); the rest of the
//   line is taken and dropped until the next line_start
// sequencing:
//   an ordinary character is decoded as it is taken; a character that
//   ends an item (',' or whitespace) also runs expansion init, one
//   expansion step per value the item expands to (at least 1, up to 60
//   for '*' on minutes) and item finish, since the expansion sets one
//   mask bit per cycle; a result also loads the output register
// stalls and reset:
//   the result sits in its own register, so characters keep flowing while it
//   waits; only a second result waits for the first to be taken
//   rst (synchronous, active high) clears the parser and drops a pending
//   result
// ----------------------------------------------------------------------------
module cron_time_spec_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  ctsp_pkg::char_t   char_item,
  output logic              result_valid,
  input  logic              result_ready,
  output ctsp_pkg::result_t result
);
  import ctsp_pkg::*;

  // controller to datapath command and datapath status
  cmd_t       cmd;
  dp_status_t sts;

  // sequencer: idle/decode, expansion init, one step per range value,
  // item finish, result load
  ctsp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // character decode, field masks and result register
  ctsp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .char_item (char_item),
    .sts       (sts),
    .result    (result)
  );

endmodule
